### hdl/xeu_pkg.sv
// ----------------------------------------------------------------------------
// XML escape with UTF-8 validation: shared package
// Item types, controller commands and status, and the byte tables.
// ----------------------------------------------------------------------------
package xeu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
        logic       any_replaced;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic halt;
        logic slot_free;
    } t_sts;

    typedef enum logic [2:0] {
        CL_PLAIN = 3'd0,
        CL_ENT   = 3'd1,
        CL_BAD   = 3'd2,
        CL_L2    = 3'd3,
        CL_L3    = 3'd4,
        CL_L4    = 3'd5
    } t_cls;

    localparam logic [7:0] QMARK = 8'h3F;

    function automatic t_cls byte_class(input logic [7:0] b);
        t_cls c;
        if (b < 8'h20) begin
            c = (b == 8'h09 || b == 8'h0A || b == 8'h0D) ? CL_PLAIN : CL_BAD;
        end else if (b < 8'h80) begin
            c = (b == 8'h22 || b == 8'h26 || b == 8'h27 || b == 8'h3C || b == 8'h3E)
                ? CL_ENT : CL_PLAIN;
        end else if (b < 8'hC0) begin
            c = CL_BAD;
        end else if (b < 8'hE0) begin
            c = CL_L2;
        end else if (b < 8'hF0) begin
            c = CL_L3;
        end else if (b < 8'hF8) begin
            c = CL_L4;
        end else begin
            c = CL_BAD;
        end
        return c;
    endfunction

    function automatic logic [2:0] ent_len(input logic [7:0] b);
        logic [2:0] n;
        case (b)
            8'h22:   n = 3'd6;
            8'h26:   n = 3'd5;
            8'h27:   n = 3'd6;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_char(input logic [7:0] b, input logic [2:0] j);
        logic [47:0] s;
        logic [7:0]  ch;
        case (b)
            8'h22:   s = "&quot;";
            8'h26:   s = {"&amp;", 8'h00};
            8'h27:   s = "&apos;";
            8'h3C:   s = {"&lt;", 16'h0000};
            default: s = {"&gt;", 16'h0000};
        endcase
        case (j)
            3'd0:    ch = s[47:40];
            3'd1:    ch = s[39:32];
            3'd2:    ch = s[31:24];
            3'd3:    ch = s[23:16];
            3'd4:    ch = s[15:8];
            default: ch = s[7:0];
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pick(input logic [31:0] v, input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = v[7:0];
            3'd1:    r = v[15:8];
            3'd2:    r = v[23:16];
            3'd3:    r = v[31:24];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

### hdl/xeu_ctrl.sv
// ----------------------------------------------------------------------------
// XML escape with UTF-8 validation: controller
// Takes one item, then steps the scan until it halts and closes the run.
// ----------------------------------------------------------------------------
module xeu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  xeu_pkg::t_sts i_sts,
    output xeu_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.slot_free) begin
                    if (i_sts.halt) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/xeu_dp.sv
// ----------------------------------------------------------------------------
// XML escape with UTF-8 validation: datapath
// Byte buffer, scan position, character decode, hold and output registers.
// ----------------------------------------------------------------------------
module xeu_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xeu_pkg::t_in_item  i_in_item,
    input  xeu_pkg::t_cmd      i_cmd,
    output xeu_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output xeu_pkg::t_out_item o_out_item
);

    logic [7:0]         r_buf [4];
    logic [2:0]         r_n;
    logic [2:0]         r_i;
    logic [2:0]         r_j;
    logic               r_final;
    logic               r_rep;
    logic               r_hv;
    logic [7:0]         r_hold;
    logic               r_ov;
    xeu_pkg::t_out_item r_out;

    logic [31:0]   w_bufv;
    logic [7:0]    w_b0;
    xeu_pkg::t_cls w_cls;
    logic [2:0]    w_avail;
    logic [2:0]    w_c;
    logic [7:0]    w_c1, w_c2, w_c3;
    logic          w_cwait, w_cbad;
    logic [2:0]    w_badk;
    logic [21:0]   w_chr;
    logic          w_vbad;
    logic          w_halt;
    logic [7:0]    w_byte;
    logic          w_done;
    logic [2:0]    w_adv;
    logic          w_setrep;
    logic          w_free;

    assign w_bufv  = {r_buf[3], r_buf[2], r_buf[1], r_buf[0]};
    assign w_b0    = xeu_pkg::pick(w_bufv, r_i);
    assign w_cls   = xeu_pkg::byte_class(w_b0);
    assign w_avail = r_n - r_i;
    assign w_c1    = xeu_pkg::pick(w_bufv, r_i + 3'd1);
    assign w_c2    = xeu_pkg::pick(w_bufv, r_i + 3'd2);
    assign w_c3    = xeu_pkg::pick(w_bufv, r_i + 3'd3);
    assign w_free  = !r_ov || !i_out_stall;

    always_comb begin
        case (w_cls)
            xeu_pkg::CL_L2: w_c = 3'd2;
            xeu_pkg::CL_L3: w_c = 3'd3;
            xeu_pkg::CL_L4: w_c = 3'd4;
            default:        w_c = 3'd1;
        endcase
    end

    always_comb begin
        logic [7:0] cb;
        logic       stop;
        w_cwait = 1'b0;
        w_cbad  = 1'b0;
        w_badk  = 3'd0;
        stop    = 1'b0;
        for (int k = 1; k < 4; k++) begin
            cb = (k == 1) ? w_c1 : ((k == 2) ? w_c2 : w_c3);
            if (!stop && 3'(k) < w_c) begin
                if (3'(k) >= w_avail) begin
                    w_cwait = 1'b1;
                    stop    = 1'b1;
                end else if (cb[7:6] != 2'b10) begin
                    w_cbad = 1'b1;
                    w_badk = 3'(k);
                    stop   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (w_c)
            3'd2:    w_chr = {10'd0, w_b0[5:0], w_c1[5:0]};
            3'd3:    w_chr = {5'd0, w_b0[4:0], w_c1[5:0], w_c2[5:0]};
            default: w_chr = {w_b0[3:0], w_c1[5:0], w_c2[5:0], w_c3[5:0]};
        endcase
        case (w_c)
            3'd2:    w_vbad = w_chr < 22'h80;
            3'd3:    w_vbad = w_chr < 22'h800 || (w_chr > 22'hD7FF && w_chr < 22'hE000)
                              || w_chr > 22'hFFFD;
            default: w_vbad = w_chr < 22'h10000 || w_chr > 22'h10FFFF;
        endcase
    end

    always_comb begin
        logic lead;
        logic cut;
        lead     = w_cls == xeu_pkg::CL_L2 || w_cls == xeu_pkg::CL_L3
                   || w_cls == xeu_pkg::CL_L4;
        cut      = w_c > w_avail;
        w_halt   = 1'b0;
        w_byte   = w_b0;
        w_done   = 1'b1;
        w_adv    = 3'd1;
        w_setrep = 1'b0;
        if (r_i >= r_n) begin
            w_halt = 1'b1;
        end else if (lead && !r_final && ({1'b0, w_c} > ({1'b0, w_avail} + 4'd1))) begin
            w_halt = 1'b1;
        end else if (lead && !(r_final && cut) && w_cwait) begin
            w_halt = 1'b1;
        end
        case (w_cls)
            xeu_pkg::CL_PLAIN: begin
                w_byte = w_b0;
            end
            xeu_pkg::CL_ENT: begin
                w_byte   = xeu_pkg::ent_char(w_b0, r_j);
                w_done   = r_j == xeu_pkg::ent_len(w_b0) - 3'd1;
                w_setrep = 1'b1;
            end
            xeu_pkg::CL_L2, xeu_pkg::CL_L3, xeu_pkg::CL_L4: begin
                if (r_final && cut) begin
                    w_byte   = xeu_pkg::QMARK;
                    w_setrep = 1'b1;
                end else if (w_cbad) begin
                    w_byte   = xeu_pkg::QMARK;
                    w_adv    = w_badk + 3'd1;
                    w_setrep = 1'b1;
                end else if (w_vbad) begin
                    w_byte   = xeu_pkg::QMARK;
                    w_adv    = w_c;
                    w_setrep = 1'b1;
                end else begin
                    w_byte = xeu_pkg::pick(w_bufv, r_i + r_j);
                    w_done = r_j == w_c - 3'd1;
                    w_adv  = w_c;
                end
            end
            default: begin
                w_byte   = xeu_pkg::QMARK;
                w_setrep = 1'b1;
            end
        endcase
    end

    assign o_sts.halt      = w_halt;
    assign o_sts.slot_free = w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= 3'd0;
            r_rep <= 1'b0;
            r_hv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if ((i_cmd.step || i_cmd.finish) && r_hv) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.load) begin
                r_buf[r_n[1:0]] <= i_in_item.in_byte;
                r_n             <= r_n + 3'd1;
                r_final         <= i_in_item.is_last;
                r_i             <= 3'd0;
                r_j             <= 3'd0;
            end
            if (i_cmd.step) begin
                if (r_hv) begin
                    r_out.out_byte      <= r_hold;
                    r_out.run_last      <= 1'b0;
                    r_out.stream_end    <= 1'b0;
                    r_out.any_replaced  <= 1'b0;
                end
                r_hv   <= 1'b1;
                r_hold <= w_byte;
                if (w_setrep) begin
                    r_rep <= 1'b1;
                end
                if (w_done) begin
                    r_i <= r_i + w_adv;
                    r_j <= 3'd0;
                end else begin
                    r_j <= r_j + 3'd1;
                end
            end
            if (i_cmd.finish) begin
                if (r_hv) begin
                    r_out.out_byte     <= r_hold;
                    r_out.run_last     <= 1'b1;
                    r_out.stream_end   <= r_final;
                    r_out.any_replaced <= r_final && r_rep;
                end
                r_hv <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_buf[k] <= xeu_pkg::pick(w_bufv, r_i + 3'(k));
                end
                r_n <= r_final ? 3'd0 : (w_avail > 3'd3 ? 3'd3 : w_avail);
                if (r_final) begin
                    r_rep <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_final |=> r_n == 3'd0)
        else $error("Pending bytes remain after the end of a stream.");

    a_final_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_final |-> r_hv)
        else $error("Stream ended without a final item.");

    a_step_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !w_halt && r_i < r_n)
        else $error("Scan stepped past a halt point.");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.stream_end |-> r_out.run_last)
        else $error("Stream end item is not the last of its run.");

endmodule

### hdl/xml_escape_utf8_validate.sv
// Each output byte passes through the hold register and then the output
// register. A new item is taken only while the controller is idle, once the
// previous item's scan has closed its run; output stalls hold the scan.
// Reset: synchronous, active low; clears the buffer count, the replaced flag
// and the hold and output valid flags.
// ----------------------------------------------------------------------------
// XML escape with UTF-8 validation
// Escapes markup characters and replaces invalid UTF-8 and disallowed control bytes with '?' per byte item.
// ----------------------------------------------------------------------------
module xml_escape_utf8_validate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  xeu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output xeu_pkg::t_out_item o_out_item
);

    xeu_pkg::t_cmd w_cmd;
    xeu_pkg::t_sts w_sts;

    xeu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    xeu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
